[rtl/core/gmwf_pkg.sv]
// gmwf_pkg: constants, payload structs and control types for the geometric mean window filter
// used by gmwf_lane, gmwf_ctrl and geometric_mean_window_filter_top
`default_nettype none

package gmwf_pkg;

  localparam int WIN         = 3;
  localparam int HALF        = WIN / 2;
  localparam int TAPS        = WIN * WIN;
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int STORE_DEPTH = 4 * WIN * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 12;
  localparam int POS_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SGN_W       = DIM_W + 1;
  localparam int PROD_W      = 8 * TAPS;
  localparam int TAP_CNT_W   = $clog2(TAPS);
  localparam int WIN_CNT_W   = $clog2(WIN);
  localparam int PIX_W       = 24;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BACK,
    ST_FETCH,
    ST_DRAIN,
    ST_SEARCH,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_last;
  } pix_out_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic start;
  } lane_ctl_t;

  typedef struct packed {
    lane_ctl_t lane;
    logic      emit;
    logic      frame_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lanes_done;
    logic out_free;
  } ctrl_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_W'(3)) r = DIM_W'(3);
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_add(input logic [ADDR_W-1:0] p,
                                                input logic [DIM_W-1:0] w);
    logic [ADDR_W:0] s;
    s = (ADDR_W+1)'(p) + (ADDR_W+1)'(w);
    if (s >= (ADDR_W+1)'(STORE_DEPTH)) s = s - (ADDR_W+1)'(STORE_DEPTH);
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_sub(input logic [ADDR_W-1:0] p,
                                                input logic [DIM_W-1:0] w);
    logic [ADDR_W:0] s;
    if ((ADDR_W+1)'(p) >= (ADDR_W+1)'(w)) s = (ADDR_W+1)'(p) - (ADDR_W+1)'(w);
    else s = (ADDR_W+1)'(p) + (ADDR_W+1)'(STORE_DEPTH) - (ADDR_W+1)'(w);
    return s[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/gmwf_lane.sv]
// gmwf_lane: one colour channel, builds the window product and searches the integer root
// bit by bit with a serial 72x8 multiplier; depends on gmwf_pkg
`default_nettype none

module gmwf_lane (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gmwf_pkg::lane_ctl_t ctl_i,
  input  wire logic [7:0]          tap_i,
  output logic                     done_o,
  output logic [7:0]               root_o
);

  logic [gmwf_pkg::PROD_W-1:0]    prod_q, pw_q;
  logic [gmwf_pkg::PROD_W+7:0]    pw_full, prod_full;
  logic [7:0]                     res_q, trial, res_nx;
  logic [2:0]                     bit_q;
  logic [gmwf_pkg::TAP_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q, fits;

  assign trial     = res_q | (8'd1 << bit_q);
  assign pw_full   = (gmwf_pkg::PROD_W+8)'(pw_q) * (gmwf_pkg::PROD_W+8)'(trial);
  assign prod_full = (gmwf_pkg::PROD_W+8)'(prod_q) * (gmwf_pkg::PROD_W+8)'(tap_i);
  assign fits      = (pw_q <= prod_q);
  assign res_nx    = fits ? trial : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == gmwf_pkg::TAP_CNT_W'(gmwf_pkg::TAPS - 1)
                   && bit_q == 3'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      prod_q <= gmwf_pkg::PROD_W'(1);
    end else if (ctl_i.mul) begin
      prod_q <= prod_full[gmwf_pkg::PROD_W-1:0];
    end
    if (ctl_i.start) begin
      bit_q <= 3'd7;
      res_q <= 8'd0;
      pw_q  <= gmwf_pkg::PROD_W'(8'h80);
      cnt_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != gmwf_pkg::TAP_CNT_W'(gmwf_pkg::TAPS - 1)) begin
        pw_q  <= pw_full[gmwf_pkg::PROD_W-1:0];
        cnt_q <= cnt_q + 1'b1;
      end else begin
        // trial^TAPS ready: keep the bit if it does not exceed the product
        res_q <= res_nx;
        if (bit_q != 3'd0) begin
          bit_q <= bit_q - 3'd1;
          pw_q  <= gmwf_pkg::PROD_W'(res_nx | (8'd1 << (bit_q - 3'd1)));
          cnt_q <= '0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q;

endmodule

`default_nettype wire

[rtl/core/gmwf_ctrl.sv]
// gmwf_ctrl: frame bookkeeping, pixel store, output cursor and window fetch sequencer
// depends on gmwf_pkg; drives the three gmwf_lane instances through the top level
`default_nettype none

module gmwf_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire gmwf_pkg::pix_in_t                in_data_i,
  input  wire logic                             cfg_valid_i,
  input  wire gmwf_pkg::cfg_idx_e               cfg_index_i,
  input  wire logic [gmwf_pkg::DIM_W-1:0]       cfg_data_i,
  input  wire gmwf_pkg::ctrl_stat_t             stat_i,
  output gmwf_pkg::ctrl_cmd_t                   cmd_o,
  output logic [gmwf_pkg::PIX_W-1:0]            tap_o
);

  localparam int DW = gmwf_pkg::DIM_W;
  localparam int AW = gmwf_pkg::ADDR_W;
  localparam int SW = gmwf_pkg::SGN_W;
  localparam int CW = gmwf_pkg::WIN_CNT_W;

  gmwf_pkg::ctrl_state_e state_q, state_d;

  logic [DW-1:0] width_q, height_q;
  logic [gmwf_pkg::POS_W-1:0] col_q, col_d, ocol_q, ocol_d;
  logic [gmwf_pkg::ROW_W-1:0] row_q, row_d, orow_q, orow_d;
  logic [DW-1:0] in_w_q, in_w_d, in_h_q, in_h_d, ow_q, ow_d, oh_q, oh_d;
  logic [AW-1:0] in_base_q, in_base_d, wr_ptr_q, wr_ptr_d, optr_q, optr_d;
  logic          in_pend_q, in_pend_d, ov_q, ov_d, olive_q, olive_d;
  logic [2:0]    n_q, n_d;
  logic [DW-1:0] col_nx, row_nx, ocol_nx, orow_nx;

  logic signed [SW-1:0] vy_q, vy_nx, sx, oh_m1s, ow_m1s;
  logic [AW-1:0]        tp_q, raddr;
  logic [CW-1:0]        cx_q, ry_q;
  logic                 rdv_q;
  logic [DW-1:0]        xcol;
  logic [DW:0]          need_r, need_c, nr, nc;
  logic                 accept, emit, win_ready, last_tap, go_fetch;
  logic [gmwf_pkg::PIX_W-1:0] mem [gmwf_pkg::STORE_DEPTH];
  logic [gmwf_pkg::PIX_W-1:0] rd_q;

  assign accept = (state_q == gmwf_pkg::ST_IDLE) && in_valid_i;
  assign emit   = (state_q == gmwf_pkg::ST_EMIT) && stat_i.out_free;

  // window of the cursor pixel complete once input has passed its lower right tap
  assign nr     = (DW+1)'(orow_q) + (DW+1)'(gmwf_pkg::HALF);
  assign nc     = (DW+1)'(ocol_q) + (DW+1)'(gmwf_pkg::HALF);
  assign need_r = (nr > (DW+1)'(oh_q - 1'b1)) ? (DW+1)'(oh_q - 1'b1) : nr;
  assign need_c = (nc > (DW+1)'(ow_q - 1'b1)) ? (DW+1)'(ow_q - 1'b1) : nc;
  assign win_ready = ((DW+1)'(row_q) > need_r)
                  || (((DW+1)'(row_q) == need_r) && ((DW+1)'(col_q) > need_c));
  assign go_fetch  = (n_q != 3'd4) && ov_q && (!olive_q || win_ready);

  assign last_tap = (cx_q == CW'(gmwf_pkg::WIN - 1)) && (ry_q == CW'(gmwf_pkg::WIN - 1));

  // tap column clamped to the frame edge
  assign ow_m1s = $signed(SW'(ow_q)) - SW'(1);
  assign oh_m1s = $signed(SW'(oh_q)) - SW'(1);
  assign sx     = $signed(SW'(ocol_q)) + $signed(SW'(cx_q)) - SW'(gmwf_pkg::HALF);
  always_comb begin
    if (sx < 0) xcol = '0;
    else if (sx > ow_m1s) xcol = ow_q - 1'b1;
    else xcol = sx[DW-1:0];
  end
  assign raddr = gmwf_pkg::ptr_add(tp_q, xcol);
  assign vy_nx = vy_q + SW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gmwf_pkg::ST_IDLE:   if (in_valid_i) state_d = gmwf_pkg::ST_CHECK;
      gmwf_pkg::ST_CHECK:  state_d = go_fetch ? gmwf_pkg::ST_BACK : gmwf_pkg::ST_IDLE;
      gmwf_pkg::ST_BACK:   if (cx_q == CW'(gmwf_pkg::HALF - 1)) state_d = gmwf_pkg::ST_FETCH;
      gmwf_pkg::ST_FETCH:  if (last_tap) state_d = gmwf_pkg::ST_DRAIN;
      gmwf_pkg::ST_DRAIN:  state_d = gmwf_pkg::ST_SEARCH;
      gmwf_pkg::ST_SEARCH: if (stat_i.lanes_done) state_d = gmwf_pkg::ST_EMIT;
      gmwf_pkg::ST_EMIT:   if (stat_i.out_free) state_d = gmwf_pkg::ST_CHECK;
      default:             state_d = gmwf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o          = (state_q != gmwf_pkg::ST_IDLE);
    cmd_o.lane.clr      = (state_q == gmwf_pkg::ST_CHECK);
    cmd_o.lane.mul      = rdv_q;
    cmd_o.lane.start    = (state_q == gmwf_pkg::ST_DRAIN);
    cmd_o.emit          = emit;
    cmd_o.frame_last    = (DW'(orow_q) == oh_q - 1'b1) && (DW'(ocol_q) == ow_q - 1'b1);
  end

  assign tap_o = rd_q;

  // frame and cursor bookkeeping
  always_comb begin
    col_d = col_q; row_d = row_q; in_w_d = in_w_q; in_h_d = in_h_q;
    in_base_d = in_base_q; wr_ptr_d = wr_ptr_q; in_pend_d = in_pend_q;
    ov_d = ov_q; olive_d = olive_q; ow_d = ow_q; oh_d = oh_q; optr_d = optr_q;
    orow_d = orow_q; ocol_d = ocol_q; n_d = n_q;
    col_nx = DW'(col_q) + 1'b1;
    row_nx = DW'(row_q) + 1'b1;
    ocol_nx = DW'(ocol_q) + 1'b1;
    orow_nx = DW'(orow_q) + 1'b1;
    if (accept) begin
      n_d = '0;
      if (row_q == '0 && col_q == '0) begin
        in_w_d    = gmwf_pkg::clamp_dim(width_q, DW'(gmwf_pkg::MAX_WIDTH));
        in_h_d    = gmwf_pkg::clamp_dim(height_q, DW'(gmwf_pkg::MAX_HEIGHT));
        in_base_d = wr_ptr_q;
        if (!ov_q) begin
          ov_d = 1'b1; olive_d = 1'b1; ow_d = in_w_d; oh_d = in_h_d;
          optr_d = in_base_d; orow_d = '0; ocol_d = '0; in_pend_d = 1'b0;
        end else begin
          in_pend_d = 1'b1;
        end
      end
      wr_ptr_d = (wr_ptr_q == AW'(gmwf_pkg::STORE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (col_nx >= in_w_d) begin
        col_d = '0;
        if (row_nx >= in_h_d) begin
          row_d = '0;
          // input frame done: an unfinished older output frame is dropped for the pending one
          if (in_pend_d) begin
            ov_d = 1'b1; ow_d = in_w_d; oh_d = in_h_d;
            optr_d = in_base_d; orow_d = '0; ocol_d = '0; in_pend_d = 1'b0;
          end
          olive_d = 1'b0;
        end else begin
          row_d = row_nx[gmwf_pkg::ROW_W-1:0];
        end
      end else begin
        col_d = col_nx[gmwf_pkg::POS_W-1:0];
      end
    end
    if (emit) begin
      n_d = n_q + 3'd1;
      if (ocol_nx >= ow_q) begin
        ocol_d = '0;
        optr_d = gmwf_pkg::ptr_add(optr_q, ow_q);
        if (orow_nx >= oh_q) begin
          ov_d = 1'b0;
          if (in_pend_q) begin
            ov_d = 1'b1; olive_d = 1'b1; ow_d = in_w_q; oh_d = in_h_q;
            optr_d = in_base_q; orow_d = '0; in_pend_d = 1'b0;
          end
        end else begin
          orow_d = orow_nx[gmwf_pkg::ROW_W-1:0];
        end
      end else begin
        ocol_d = ocol_nx[gmwf_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gmwf_pkg::ST_IDLE;
      width_q   <= gmwf_pkg::WIDTH_RST;
      height_q  <= gmwf_pkg::HEIGHT_RST;
      col_q     <= '0;
      row_q     <= '0;
      in_w_q    <= DW'(3);
      in_h_q    <= DW'(3);
      in_base_q <= '0;
      wr_ptr_q  <= '0;
      in_pend_q <= 1'b0;
      ov_q      <= 1'b0;
      olive_q   <= 1'b0;
      ow_q      <= DW'(3);
      oh_q      <= DW'(3);
      optr_q    <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      n_q       <= '0;
      rdv_q     <= 1'b0;
      cx_q      <= '0;
      ry_q      <= '0;
    end else begin
      state_q   <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == gmwf_pkg::CFG_WIDTH) width_q <= cfg_data_i;
        else height_q <= cfg_data_i;
      end
      col_q     <= col_d;
      row_q     <= row_d;
      in_w_q    <= in_w_d;
      in_h_q    <= in_h_d;
      in_base_q <= in_base_d;
      wr_ptr_q  <= wr_ptr_d;
      in_pend_q <= in_pend_d;
      ov_q      <= ov_d;
      olive_q   <= olive_d;
      ow_q      <= ow_d;
      oh_q      <= oh_d;
      optr_q    <= optr_d;
      orow_q    <= orow_d;
      ocol_q    <= ocol_d;
      n_q       <= n_d;
      rdv_q     <= (state_q == gmwf_pkg::ST_FETCH);
      case (state_q)
        gmwf_pkg::ST_CHECK: begin
          cx_q <= '0;
          ry_q <= '0;
        end
        gmwf_pkg::ST_BACK: begin
          cx_q <= (cx_q == CW'(gmwf_pkg::HALF - 1)) ? '0 : cx_q + 1'b1;
        end
        gmwf_pkg::ST_FETCH: begin
          if (cx_q == CW'(gmwf_pkg::WIN - 1)) begin
            cx_q <= '0;
            ry_q <= ry_q + 1'b1;
          end else begin
            cx_q <= cx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // window row pointer walks up to the top tap row, then down row by row
  always_ff @(posedge clk_i) begin
    case (state_q)
      gmwf_pkg::ST_CHECK: begin
        vy_q <= $signed(SW'(orow_q));
        tp_q <= optr_q;
      end
      gmwf_pkg::ST_BACK: begin
        if (vy_q > 0) tp_q <= gmwf_pkg::ptr_sub(tp_q, ow_q);
        vy_q <= vy_q - SW'(1);
      end
      gmwf_pkg::ST_FETCH: begin
        if (cx_q == CW'(gmwf_pkg::WIN - 1)) begin
          if (vy_nx > 0 && vy_nx <= oh_m1s) tp_q <= gmwf_pkg::ptr_add(tp_q, ow_q);
          vy_q <= vy_nx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) mem[wr_ptr_q] <= in_data_i;
    if (state_q == gmwf_pkg::ST_FETCH) rd_q <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/geometric_mean_window_filter_top.sv]
// geometric_mean_window_filter_top: controller, three channel lanes and the result register
// depends on gmwf_pkg, gmwf_ctrl and gmwf_lane
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid_i/in_stall_o   gmwf_pkg::pix_in_t (blue, green, red)
//   out_*        out   out_valid_o/out_stall_i gmwf_pkg::pix_out_t (means, frame_last)
//   cfg_*        in    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i (width, height)
//
// each input transfer is followed by a readiness check, then each result it releases (0 to 4)
// takes store reads of its window taps, a bit-by-bit root search and a load of the result
// register; the serial 72x8 multiply in each lane sets the length of the root search.
// reset returns the geometry to 640 x 480 and empties the cursor; the pixel store is not
// cleared. input is stalled while an item's results are worked out or wait at the output
`default_nettype none

module geometric_mean_window_filter_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire gmwf_pkg::pix_in_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output gmwf_pkg::pix_out_t               out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire gmwf_pkg::cfg_idx_e          cfg_index_i,
  input  wire logic [gmwf_pkg::DIM_W-1:0]  cfg_data_i
);

  gmwf_pkg::ctrl_cmd_t        cmd;
  gmwf_pkg::ctrl_stat_t       stat;
  logic [gmwf_pkg::PIX_W-1:0] tap;
  logic [2:0]                 done;
  logic [7:0]                 root_b, root_g, root_r;
  logic                       out_valid_q;
  gmwf_pkg::pix_out_t         out_q;

  assign cfg_ready_o     = 1'b1;
  assign stat.out_free   = !out_valid_q || !out_stall_i;
  assign stat.lanes_done = &done;

  gmwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .tap_o       (tap)
  );

  // pixel word: blue in the top byte, red in the bottom byte
  gmwf_lane u_lane_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (cmd.lane),
    .tap_i (tap[23:16]), .done_o (done[0]), .root_o (root_b)
  );

  gmwf_lane u_lane_g (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (cmd.lane),
    .tap_i (tap[15:8]), .done_o (done[1]), .root_o (root_g)
  );

  gmwf_lane u_lane_r (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (cmd.lane),
    .tap_i (tap[7:0]), .done_o (done[2]), .root_o (root_r)
  );

  // merge the lane roots into one result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_q.blue_out   <= root_b;
      out_q.green_out  <= root_g;
      out_q.red_out    <= root_r;
      out_q.frame_last <= cmd.frame_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done[0] == done[1]) && (done[1] == done[2]))
    else $error("colour lanes finished out of step");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over an untaken one");

  a_emit_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> in_stall_o)
    else $error("input open while a result is released");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("released result not presented");

endmodule

`default_nettype wire

[test/tb_geometric_mean_window_filter_top.sv]
// tb_geometric_mean_window_filter_top: self-checking bench for the geometric mean window filter
// depends on gmwf_pkg and geometric_mean_window_filter_top; keeps its own store and predictor
`timescale 1ns / 100ps

module tb_geometric_mean_window_filter_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 400;

  typedef struct {
    gmwf_pkg::pix_in_t px;
    int                known;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  gmwf_pkg::pix_in_t  in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  gmwf_pkg::pix_out_t out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  gmwf_pkg::cfg_idx_e cfg_index_i;
  logic [gmwf_pkg::DIM_W-1:0] cfg_data_i;

  geometric_mean_window_filter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // predictor state
  logic [23:0] pix_store [gmwf_pkg::STORE_DEPTH];
  logic [gmwf_pkg::DIM_W-1:0] width_reg, height_reg;
  int col_cnt, row_cnt, in_w, in_h, in_base, wr_ptr;
  bit in_pending, emit_valid, emit_live;
  int emit_w, emit_h, emit_base, emit_row, emit_col;

  gmwf_pkg::pix_out_t mean_q[$];
  int send_pct, recv_pct;
  int hold_trig, hold_seen, hold_left;
  int errors, items_sent, results_seen, cycles;

  function automatic int dim_limit(logic [gmwf_pkg::DIM_W-1:0] v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [7:0] nth_root(logic [71:0] taps);
    logic [71:0] prod, pw, m;
    int lo, hi, mid;
    prod = 72'd1;
    for (int k = 0; k < gmwf_pkg::TAPS; k++) prod = prod * taps[8*k +: 8];
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      m = mid;
      pw = 72'd1;
      for (int k = 0; k < gmwf_pkg::TAPS; k++) pw = pw * m;
      if (pw <= prod) lo = mid;
      else hi = mid - 1;
    end
    return lo[7:0];
  endfunction

  function automatic void open_output_frame(bit live);
    emit_valid = 1;
    emit_live  = live;
    emit_w     = in_w;
    emit_h     = in_h;
    emit_base  = in_base;
    emit_row   = 0;
    emit_col   = 0;
    in_pending = 0;
  endfunction

  function automatic void predictor_reset();
    width_reg  = gmwf_pkg::WIDTH_RST;
    height_reg = gmwf_pkg::HEIGHT_RST;
    col_cnt = 0; row_cnt = 0;
    in_w = 3; in_h = 3; in_base = 0; wr_ptr = 0;
    in_pending = 0; emit_valid = 0; emit_live = 0;
    emit_w = 3; emit_h = 3; emit_base = 0; emit_row = 0; emit_col = 0;
  endfunction

  // store one pixel and queue the window means it releases, at most four
  function automatic void predict_means(gmwf_pkg::pix_in_t px);
    int n, need_r, need_c, y, x, k;
    logic [71:0] tb, tg, tr;
    logic [23:0] p;
    gmwf_pkg::pix_out_t r;
    n = 0;
    if (row_cnt == 0 && col_cnt == 0) begin
      in_w = dim_limit(width_reg, gmwf_pkg::MAX_WIDTH);
      in_h = dim_limit(height_reg, gmwf_pkg::MAX_HEIGHT);
      in_base = wr_ptr;
      if (!emit_valid) open_output_frame(1);
      else in_pending = 1;
    end
    pix_store[wr_ptr] = {px.red_in, px.green_in, px.blue_in};
    wr_ptr = (wr_ptr + 1 >= gmwf_pkg::STORE_DEPTH) ? 0 : wr_ptr + 1;
    col_cnt++;
    if (col_cnt >= in_w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= in_h) begin
        row_cnt = 0;
        if (in_pending) open_output_frame(0);
        emit_live = 0;
      end
    end
    while (n < 4 && emit_valid) begin
      need_r = emit_row + gmwf_pkg::HALF;
      need_c = emit_col + gmwf_pkg::HALF;
      if (need_r > emit_h - 1) need_r = emit_h - 1;
      if (need_c > emit_w - 1) need_c = emit_w - 1;
      if (emit_live && !(row_cnt > need_r || (row_cnt == need_r && col_cnt > need_c))) break;
      k = 0;
      for (int dy = -gmwf_pkg::HALF; dy <= gmwf_pkg::HALF; dy++) begin
        for (int dx = -gmwf_pkg::HALF; dx <= gmwf_pkg::HALF; dx++) begin
          y = emit_row + dy;
          x = emit_col + dx;
          if (y < 0) y = 0;
          if (y > emit_h - 1) y = emit_h - 1;
          if (x < 0) x = 0;
          if (x > emit_w - 1) x = emit_w - 1;
          p = pix_store[(emit_base + y * emit_w + x) % gmwf_pkg::STORE_DEPTH];
          tb[8*k +: 8] = p[7:0];
          tg[8*k +: 8] = p[15:8];
          tr[8*k +: 8] = p[23:16];
          k++;
        end
      end
      r.blue_out   = nth_root(tb);
      r.green_out  = nth_root(tg);
      r.red_out    = nth_root(tr);
      r.frame_last = (emit_row == emit_h - 1 && emit_col == emit_w - 1);
      mean_q.push_back(r);
      n++;
      emit_col++;
      if (emit_col >= emit_w) begin
        emit_col = 0;
        emit_row++;
        if (emit_row >= emit_h) begin
          emit_valid = 0;
          if (in_pending) open_output_frame(1);
        end
      end
    end
  endfunction

  function automatic gmwf_pkg::pix_in_t rand_pixel();
    gmwf_pkg::pix_in_t px;
    px.blue_in  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255)
                                              : 8'($urandom_range(1, 255));
    px.green_in = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255)
                                              : 8'($urandom_range(1, 255));
    px.red_in   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255)
                                              : 8'($urandom_range(1, 255));
    return px;
  endfunction

  // result side: random stall plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_seen != hold_trig) begin
      hold_seen = hold_trig;
      hold_left = 700;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < recv_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (mean_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer %p", out_data_o);
      end else begin
        if (out_data_o !== mean_q[0]) begin
          errors++;
          if (errors <= 10)
            $display({"result %0d mismatch: expected b=%0d g=%0d r=%0d last=%0b,",
                      " got b=%0d g=%0d r=%0d last=%0b"},
                     results_seen, mean_q[0].blue_out, mean_q[0].green_out,
                     mean_q[0].red_out, mean_q[0].frame_last, out_data_o.blue_out,
                     out_data_o.green_out, out_data_o.red_out, out_data_o.frame_last);
        end
        void'(mean_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_geometric_mean_window_filter_top: done, errors");
      $finish;
    end
  end

  task automatic send_pixel(input gmwf_pkg::pix_in_t px, input int known);
    int first;
    bit done;
    while ($urandom_range(0, 99) < send_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = px;
    done = 0;
    while (!done) begin
      @(posedge clk_i);
      if (!in_stall_o) done = 1;
    end
    first = mean_q.size();
    predict_means(px);
    if (known >= 0)
      for (int i = first; i < mean_q.size(); i++) begin
        mean_q[i].blue_out  = 8'(known);
        mean_q[i].green_out = 8'(known);
        mean_q[i].red_out   = 8'(known);
      end
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (mean_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input gmwf_pkg::cfg_idx_e idx,
                           input logic [gmwf_pkg::DIM_W-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == gmwf_pkg::CFG_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel(), -1);
  endtask

  dir_row_t dir_tab [27];

  initial begin
    in_valid_i = 1'b0;
    in_data_i  = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = gmwf_pkg::CFG_WIDTH;
    cfg_data_i  = '0;
    send_pct = 15; recv_pct = 77;
    hold_trig = 0; hold_seen = 0; hold_left = 0;
    errors = 0; items_sent = 0; results_seen = 0; cycles = 0;
    predictor_reset();

    // all-max frame, all-zero frame, then single-bit and alternating patterns
    for (int i = 0; i < 9; i++) dir_tab[i] = '{'{8'hFF, 8'hFF, 8'hFF}, 255};
    for (int i = 9; i < 18; i++) dir_tab[i] = '{'{8'h00, 8'h00, 8'h00}, 0};
    dir_tab[9].known = -1;   // flushes the tail of the all-max frame
    dir_tab[18] = '{'{8'h01, 8'h80, 8'hFF}, -1};
    dir_tab[19] = '{'{8'h02, 8'h40, 8'hFE}, -1};
    dir_tab[20] = '{'{8'h04, 8'h20, 8'hFD}, -1};
    dir_tab[21] = '{'{8'h08, 8'h10, 8'hFB}, -1};
    dir_tab[22] = '{'{8'h10, 8'h08, 8'hF7}, -1};
    dir_tab[23] = '{'{8'h20, 8'h04, 8'hEF}, -1};
    dir_tab[24] = '{'{8'h40, 8'h02, 8'hDF}, -1};
    dir_tab[25] = '{'{8'hAA, 8'h55, 8'hBF}, -1};
    dir_tab[26] = '{'{8'h55, 8'hAA, 8'h7F}, -1};

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // out-of-range values: width over the limit is replaced before use, zero acts as 3
    write_reg(gmwf_pkg::CFG_WIDTH, 12'hFFF);
    write_reg(gmwf_pkg::CFG_WIDTH, 12'd0);
    write_reg(gmwf_pkg::CFG_HEIGHT, 12'd3);
    for (int i = 0; i < 27; i++) send_pixel(dir_tab[i].px, dir_tab[i].known);
    send_random(9);
    wait_drained();

    write_reg(gmwf_pkg::CFG_WIDTH, 12'd5);
    write_reg(gmwf_pkg::CFG_HEIGHT, 12'd4);
    send_random(20);
    wait_drained();

    // long output hold-off so the block backs up, then a full pause of the sender
    write_reg(gmwf_pkg::CFG_WIDTH, 12'd6);
    write_reg(gmwf_pkg::CFG_HEIGHT, 12'd3);
    send_random(6);
    hold_trig++;
    send_random(6);
    while (mean_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    send_random(6);
    wait_drained();

    send_pct = 77; recv_pct = 15;
    write_reg(gmwf_pkg::CFG_WIDTH, 12'd7);
    send_random(21);
    wait_drained();

    // narrow frame, height over the limit
    send_pct = 0; recv_pct = 0;
    write_reg(gmwf_pkg::CFG_WIDTH, 12'd3);
    write_reg(gmwf_pkg::CFG_HEIGHT, 12'hFFF);
    send_random(30);
    wait_drained();

    if (mean_q.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", mean_q.size());
    end
    $display("%0d pixels in, %0d window means checked over five geometries", items_sent,
             results_seen);
    $display("covered flat and zero frames, frame tails, a long output hold-off and a tall frame");
    if (errors == 0) begin
      $display("tb_geometric_mean_window_filter_top: done, clean");
    end else begin
      $display("tb_geometric_mean_window_filter_top: done, errors");
    end
    $finish;
  end

endmodule
